>>> rtl/prl_pkg.sv
// shared constants and types of the zero-run leb128 position encoder
package prl_pkg;

    localparam int LEB_DIGIT_BITS = 7;
    localparam int LEB_BYTE_BITS  = 8;

    typedef logic [LEB_BYTE_BITS-1:0] leb_byte_t;

    typedef struct packed {
        logic valid;
        logic last;
    } ld_ctrl_t;

endpackage

>>> rtl/prl_if.sv
// request channels of the encoder: position words in, leb128 bytes out
interface prl_in_if #(
    parameter int POSITION_BITS = 41
);
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] position;
    logic                            last_in;

    modport source (output valid, output position, output last_in, input ready);
    modport sink (input valid, input position, input last_in, output ready);
endinterface

interface prl_out_if;
    logic                        valid;
    logic                        ready;
    logic [prl_pkg::LEB_BYTE_BITS-1:0] out_byte;
    logic                        last_out;

    modport source (output valid, output out_byte, output last_out, input ready);
    modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

>>> rtl/prl_leb_ser.sv
// digit-serial signed leb128 serializer with registered byte output
module prl_leb_ser #(
    parameter int VAL_W = 42
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prl_pkg::ld_ctrl_t   ld,
    input  logic [VAL_W-1:0]    ld_value,
    output logic                ld_ready,
    prl_out_if.source           out_ch
);
    import prl_pkg::*;

    logic                      busy_reg, busy_next;
    logic                      last_reg, last_next;
    logic [VAL_W-1:0]          val_reg, val_next;
    logic                      ovalid_reg, ovalid_next;
    logic                      olast_reg, olast_next;
    leb_byte_t                 obyte_reg, obyte_next;

    logic                      out_free;
    logic                      step;
    logic                      done;
    logic [VAL_W-1:0]          shifted;
    logic [LEB_DIGIT_BITS-1:0] digit;

    assign out_free = !ovalid_reg || out_ch.ready;
    assign step     = busy_reg && out_free;
    assign digit    = val_reg[LEB_DIGIT_BITS-1:0];
    assign shifted  = VAL_W'($signed(val_reg) >>> LEB_DIGIT_BITS);
    assign done     = ((shifted == '0) && !digit[LEB_DIGIT_BITS-1]) ||
                      ((shifted == '1) && digit[LEB_DIGIT_BITS-1]);
    assign ld_ready = !busy_reg || (step && done);

    always_comb
    begin
        busy_next   = busy_reg;
        last_next   = last_reg;
        val_next    = val_reg;
        ovalid_next = ovalid_reg;
        olast_next  = olast_reg;
        obyte_next  = obyte_reg;
        if (step)
        begin
            ovalid_next = 1'b1;
            obyte_next  = {~done, digit};
            olast_next  = done && last_reg;
            val_next    = shifted;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (ld.valid && ld_ready)
        begin
            busy_next = 1'b1;
            val_next  = ld_value;
            last_next = ld.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        val_reg   <= val_next;
        olast_reg <= olast_next;
        obyte_reg <= obyte_next;
    end

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.out_byte = obyte_reg;
    assign out_ch.last_out = olast_reg;
endmodule

>>> rtl/position_run_length_leb128_encoder_core.sv
// top level of the zero-run position encoder with signed leb128 output
// usage:
// in_ch carries one signed position word and its last_in marker per request.
// out_ch carries one signed leb128 byte per request; last_out marks the final
// byte of an encoded list.
// zero words are counted; the run goes out as one value when a nonzero word
// arrives, the list ends or the counter fills. a nonzero word goes out as one
// value right after any pending run.
// each value is serialized 7 bits per cycle through a shift register, while the
// output register is free to take the next byte.
// an accepted value is first loaded into the shift register and its first byte
// is then registered into the output register. a new word is taken in the
// cycle the final byte of the previous item moves into the output register.
// reset empties the output register, clears the run count and sets the prior
// negative word to 1. when the receiver stalls, the output byte holds, the
// serializer waits and in_ch.ready drops until room opens again.
module position_run_length_leb128_encoder_core #(
    parameter int RUN_BITS      = 32,
    parameter int POSITION_BITS = 41
) (
    input  logic      clk,
    input  logic      rst_n,
    prl_in_if.sink    in_ch,
    prl_out_if.source out_ch
);
    import prl_pkg::*;

    localparam int VAL_W = (RUN_BITS + 2 > POSITION_BITS + 1) ? RUN_BITS + 2
                                                              : POSITION_BITS + 1;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORD = 1'b1;

    logic                            state_reg, state_next;
    logic [RUN_BITS-1:0]             zero_run_reg, zero_run_next;
    logic signed [POSITION_BITS-1:0] prior_neg_reg, prior_neg_next;
    logic [VAL_W-1:0]                word_val_reg, word_val_next;
    logic                            word_last_reg, word_last_next;

    logic                            ser_ready;
    ld_ctrl_t                        ld;
    logic [VAL_W-1:0]                ld_value;

    logic                            accept;
    logic                            pos_zero;
    logic                            pos_neg;
    logic                            dup;
    logic [RUN_BITS-1:0]             run_inc;
    logic                            run_full;
    logic [RUN_BITS-1:0]             run_src;
    logic                            emit_run;
    logic                            emit_word;
    logic signed [POSITION_BITS-1:0] code;
    logic [VAL_W-1:0]                run_val;
    logic [VAL_W-1:0]                word_val;

    assign in_ch.ready = (state_reg == ST_IDLE) && ser_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign pos_zero  = (in_ch.position == '0);
    assign pos_neg   = in_ch.position[POSITION_BITS-1];
    assign dup       = pos_neg && (in_ch.position == prior_neg_reg);
    assign run_inc   = zero_run_reg + RUN_BITS'(1);
    assign run_full  = (run_inc == '1);
    assign run_src   = pos_zero ? run_inc : zero_run_reg;
    assign emit_run  = pos_zero ? (run_full || in_ch.last_in) : (zero_run_reg != '0);
    assign emit_word = !pos_zero;
    assign code      = dup ? '0 : in_ch.position;
    assign run_val   = VAL_W'({run_src, 1'b0});
    assign word_val  = VAL_W'($signed({code, 1'b1}));

    always_comb
    begin
        state_next     = state_reg;
        zero_run_next  = zero_run_reg;
        prior_neg_next = prior_neg_reg;
        word_val_next  = word_val_reg;
        word_last_next = word_last_reg;
        ld.valid       = 1'b0;
        ld.last        = 1'b0;
        ld_value       = word_val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    word_val_next  = word_val;
                    word_last_next = in_ch.last_in;
                    ld.valid       = emit_run || emit_word;
                    if (emit_run)
                    begin
                        ld_value = run_val;
                        ld.last  = in_ch.last_in && !emit_word;
                        if (emit_word)
                        begin
                            state_next = ST_WORD;
                        end
                    end
                    else
                    begin
                        ld_value = word_val;
                        ld.last  = in_ch.last_in;
                    end
                    if (pos_zero)
                    begin
                        zero_run_next = (run_full || in_ch.last_in) ? '0 : run_inc;
                    end
                    else
                    begin
                        zero_run_next = '0;
                        if (pos_neg && !dup)
                        begin
                            prior_neg_next = in_ch.position;
                        end
                    end
                    if (in_ch.last_in)
                    begin
                        prior_neg_next = POSITION_BITS'(1);
                    end
                end
            end
            ST_WORD:
            begin
                ld.valid = ser_ready;
                ld.last  = word_last_reg;
                ld_value = word_val_reg;
                if (ser_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zero_run_reg  <= '0;
            prior_neg_reg <= POSITION_BITS'(1);
        end
        else
        begin
            state_reg     <= state_next;
            zero_run_reg  <= zero_run_next;
            prior_neg_reg <= prior_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_val_reg  <= word_val_next;
        word_last_reg <= word_last_next;
    end

    prl_leb_ser #(
        .VAL_W (VAL_W)
    ) u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .ld_value (ld_value),
        .ld_ready (ser_ready),
        .out_ch   (out_ch)
    );
endmodule

>>> verif/testbench.sv
// self-checking bench for the zero-run position encoder with signed leb128 output
`timescale 1ns / 100ps

module testbench;

    import prl_pkg::*;

    localparam int RUN_BITS      = 32;
    localparam int POSITION_BITS = 41;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = ~POS_MIN;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] position;
        logic                            last;
    } position_word_t;

    typedef struct packed {
        leb_byte_t out_byte;
        logic      last_out;
    } leb_request_t;

    logic clk;
    logic rst_n;

    prl_in_if #(.POSITION_BITS(POSITION_BITS)) in_ch ();
    prl_out_if out_ch ();

    position_run_length_leb128_encoder_core #(
        .RUN_BITS     (RUN_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    logic [RUN_BITS-1:0]             zero_run;
    logic signed [POSITION_BITS-1:0] prior_negative;

    position_word_t words_to_send[$];
    leb_request_t   bytes_due[$];

    int   words_queued;
    int   words_taken;
    int   errors;
    int   burst_left;
    int   gap_left;
    int   hold_asked;
    int   hold_done;
    int   hold_left;
    int   rx_cycle;
    int   stall_cycles;
    logic in_fire;

    always #1 clk = ~clk;

    function automatic void push_leb128(input logic signed [63:0] value);
        logic signed [63:0] rest;
        logic [6:0]         digit;
        logic               done;
        rest = value;
        do
        begin
            digit = rest[6:0];
            rest  = rest >>> 7;
            done  = (rest == 64'sd0 && !digit[6]) || (rest == -64'sd1 && digit[6]);
            bytes_due.insert(bytes_due.size(), {!done, digit, 1'b0});
        end
        while (!done);
    endfunction

    function automatic void encode_position(input logic signed [POSITION_BITS-1:0] word,
                                            input logic last);
        logic signed [63:0] code;
        int                 first;
        first = bytes_due.size();
        code  = 64'(word);
        if (word == 0)
        begin
            zero_run = zero_run + RUN_BITS'(1);
            if (zero_run == '1)
            begin
                push_leb128(64'(zero_run) << 1);
                zero_run = '0;
            end
        end
        else
        begin
            if (zero_run != 0)
            begin
                push_leb128(64'(zero_run) << 1);
                zero_run = '0;
            end
            if (word < 0)
            begin
                if (word == prior_negative)
                    code = 64'sd0;
                else
                    prior_negative = word;
            end
            push_leb128((code <<< 1) | 64'sd1);
        end
        if (last)
        begin
            if (zero_run != 0)
            begin
                push_leb128(64'(zero_run) << 1);
                zero_run = '0;
            end
            if (bytes_due.size() > first)
                bytes_due[bytes_due.size() - 1].last_out = 1'b1;
            prior_negative = POSITION_BITS'(1);
        end
    endfunction

    task automatic report_fault(input string what, input leb_request_t want,
                                input leb_request_t got);
        errors++;
        if (errors <= 10)
            $display("%s: expected byte %02h last %0d, got byte %02h last %0d",
                     what, want.out_byte, want.last_out, got.out_byte, got.last_out);
    endtask

    task automatic queue_word(input logic signed [POSITION_BITS-1:0] word, input logic last);
        words_to_send.insert(words_to_send.size(), {word, last});
        words_queued++;
    endtask

    function automatic logic signed [POSITION_BITS-1:0] random_size();
        logic [63:0] r;
        int          nbits;
        nbits = $urandom_range(1, POSITION_BITS - 1);
        r = {$urandom, $urandom} & ((64'd1 << nbits) - 64'd1);
        if (r == 0)
            r = 64'd1;
        return r[POSITION_BITS-1:0];
    endfunction

    function automatic logic signed [POSITION_BITS-1:0] random_reference();
        logic [63:0] r;
        int          nbits;
        nbits = $urandom_range(0, POSITION_BITS - 1);
        r = ~({$urandom, $urandom} & ((64'd1 << nbits) - 64'd1));
        return r[POSITION_BITS-1:0];
    endfunction

    // duplicates come from a small pool of references per list
    task automatic queue_list(input int words);
        logic signed [POSITION_BITS-1:0] refs [4];
        logic signed [POSITION_BITS-1:0] word;
        int                              zero_pct;
        int                              pick;
        zero_pct = $urandom_range(0, 70);
        for (int i = 0; i < 4; i++)
            refs[i] = random_reference();
        for (int i = 0; i < words; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < zero_pct)
                word = '0;
            else if (pick < zero_pct + 30)
                word = refs[$urandom_range(0, 3)];
            else
                word = random_size();
            queue_word(word, i == words - 1);
        end
    endtask

    task automatic wait_for_drain();
        while (words_taken != words_queued || bytes_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        leb_request_t want;
        leb_request_t got;
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (in_fire)
        begin
            encode_position(in_ch.position, in_ch.last_in);
            words_taken++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.out_byte, out_ch.last_out};
            if (bytes_due.size() == 0)
                report_fault("unexpected byte", '0, got);
            else
            begin
                want = bytes_due.pop_front();
                if (want.out_byte !== got.out_byte || want.last_out !== got.last_out)
                    report_fault("mismatch", want, got);
            end
        end
    end

    always @(negedge clk)
    begin
        position_word_t item;
        if (!in_ch.valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (words_to_send.size() > 0)
            begin
                item = words_to_send.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.position <= item.position;
                in_ch.last_in  <= item.last;
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 3) == 0)
                begin
                    burst_left = $urandom_range(20, 60);
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = $urandom_range(1, 8);
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_done != hold_asked && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_done++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 300) % 4)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1) == 1;
                2: out_ch.ready <= $urandom_range(0, 3) == 0;
                default: out_ch.ready <= (rx_cycle % 5) != 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.position = '0;
        in_ch.last_in  = 1'b0;
        out_ch.ready   = 1'b0;
        in_fire        = 1'b0;
        zero_run       = '0;
        prior_negative = POSITION_BITS'(1);
        words_queued   = 0;
        words_taken    = 0;
        errors         = 0;
        burst_left     = 0;
        gap_left       = 0;
        hold_asked     = 0;
        hold_done      = 0;
        hold_left      = 0;
        rx_cycle       = 0;
        stall_cycles   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // first negative, duplicate, run flush, extremes, byte-length edges
        queue_word(POSITION_BITS'(1), 1'b0);
        queue_word(POSITION_BITS'(-5), 1'b0);
        queue_word(POSITION_BITS'(-5), 1'b0);
        queue_word('0, 1'b0);
        queue_word('0, 1'b0);
        queue_word('0, 1'b0);
        queue_word(POSITION_BITS'(7), 1'b0);
        queue_word(POS_MIN, 1'b0);
        queue_word(POS_MIN, 1'b0);
        queue_word(POSITION_BITS'(-5), 1'b0);
        queue_word(POS_MAX, 1'b0);
        queue_word(POSITION_BITS'(31), 1'b0);
        queue_word(POSITION_BITS'(32), 1'b0);
        queue_word(POSITION_BITS'(-1), 1'b0);
        queue_word(POSITION_BITS'(-32), 1'b0);
        queue_word(POSITION_BITS'(-33), 1'b0);
        queue_word('0, 1'b0);
        queue_word('0, 1'b1);
        // prior reference cleared at list end
        queue_word(POSITION_BITS'(-33), 1'b1);
        queue_word('0, 1'b0);
        queue_word(POSITION_BITS'(3), 1'b1);
        queue_word('0, 1'b1);
        queue_word(POSITION_BITS'(5), 1'b1);
        wait_for_drain();

        @(posedge clk);
        hold_asked++;
        for (int i = 0; i < 13; i++)
            queue_list($urandom_range(1, 16));
        wait_for_drain();

        @(posedge clk);
        for (int i = 0; i < 13; i++)
            queue_list($urandom_range(1, 16));
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && bytes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/prl_pkg.sv
rtl/prl_if.sv
rtl/prl_leb_ser.sv
rtl/position_run_length_leb128_encoder_core.sv
verif/testbench.sv
